/* hdl/sfs_pkg.sv */
// ----------------------------------------------------------------------------
// sfs_pkg
// shared widths, codes, register indexes and the controller command bundle
// of the sprite frame sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

	// fixed field widths
	localparam int OP_W        = 2;
	localparam int PATTERN_W   = 10;
	localparam int INDEX_W     = 5;
	localparam int OFFSET_W    = 16;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;
	localparam int MODE_W      = 3;
	localparam int INTERVAL_W  = 16;
	localparam int COL_W       = 7;
	localparam int CELL_W      = 16;
	localparam int TLEN_W      = 6;
	localparam int TICK_W      = 17;

	// parameter defaults
	localparam int TABLE_DEPTH_DEF  = 32;
	localparam int PATTERN_BITS_DEF = 10;

	// operations
	localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
	localparam logic [OP_W-1:0] OP_SET     = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd3;

	// animation modes
	localparam logic [MODE_W-1:0] MODE_FWD_LOOP = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REV_LOOP = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FWD_ONCE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REV_ONCE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PINGPONG = 3'd4;
	localparam logic [MODE_W-1:0] MODE_TBL_LOOP = 3'd5;
	localparam logic [MODE_W-1:0] MODE_TBL_ONCE = 3'd6;
	localparam logic [MODE_W-1:0] MODE_OFF      = 3'd7;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TOP      = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM   = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS  = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CELL_W   = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_CELL_H   = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_TLEN     = 4'd7;

	// register reset values
	localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd1;
	localparam logic [COL_W-1:0]      COLUMNS_RST  = 7'd1;
	localparam logic [CELL_W-1:0]     CELL_RST     = 16'hFFFF;

	// controller to datapath commands
	typedef struct packed {
		logic load_item;
		logic rd_table;
		logic update;
		logic div_step;
		logic mul;
		logic load_out;
	} sfs_cmd_t;

endpackage

`default_nettype wire

/* hdl/sfs_ram.sv */
// ----------------------------------------------------------------------------
// sfs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              re,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* hdl/sfs_ctrl.sv */
// ----------------------------------------------------------------------------
// sfs_ctrl
// sequencing state machine: item capture, table read, state update,
// bit-serial divide, multiply and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_ctrl #(
	parameter int PATTERN_BITS = sfs_pkg::PATTERN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	output logic              result_valid,
	input  logic              result_stall,
	output sfs_pkg::sfs_cmd_t cmd
);
	import sfs_pkg::*;

	localparam int CNT_W = $clog2(PATTERN_BITS + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_UPDATE = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_MUL    = 3'd4;
	localparam logic [2:0] ST_LOAD   = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] step_q;
	logic             out_full_q;
	logic             accept;
	logic             slot_free;

	assign accept    = item_valid && (state_q == ST_IDLE);
	assign slot_free = !out_full_q || !result_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_READ;
			end
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == CNT_W'(1)) state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_LOAD;
			ST_LOAD: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_UPDATE) begin
				step_q <= CNT_W'(PATTERN_BITS);
			end else if (state_q == ST_DIV) begin
				step_q <= step_q - CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_full_q <= 1'b1;
			end else if (!result_stall) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd.load_item = accept;
		cmd.rd_table  = (state_q == ST_READ);
		cmd.update    = (state_q == ST_UPDATE);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.mul       = (state_q == ST_MUL);
		cmd.load_out  = (state_q == ST_LOAD) && slot_free;
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_full_q;

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> (state_q == ST_READ))
		else $error("accepted item did not start a table read");

	a_load_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && out_full_q && result_stall) |=> (state_q == ST_LOAD))
		else $error("result overwritten while output beat stalled");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (step_q != '0))
		else $error("divider running with exhausted step count");

endmodule

`default_nettype wire

/* hdl/sfs_dp.sv */
// ----------------------------------------------------------------------------
// sfs_dp
// datapath: configuration registers, animation state, order table,
// restoring divider and offset multipliers, output register
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_dp #(
	parameter int TABLE_DEPTH  = sfs_pkg::TABLE_DEPTH_DEF,
	parameter int PATTERN_BITS = sfs_pkg::PATTERN_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sfs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [sfs_pkg::OP_W-1:0]         operation,
	input  logic [sfs_pkg::PATTERN_W-1:0]    pattern_value,
	input  logic [sfs_pkg::INDEX_W-1:0]      table_index,
	input  sfs_pkg::sfs_cmd_t                cmd,
	output logic [sfs_pkg::PATTERN_W-1:0]    pattern,
	output logic [sfs_pkg::OFFSET_W-1:0]     u_offset,
	output logic [sfs_pkg::OFFSET_W-1:0]     v_offset,
	output logic                             finished
);
	import sfs_pkg::*;

	localparam int PB      = PATTERN_BITS;
	localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LEN_W   = $clog2(TABLE_DEPTH + 1);
	localparam int LW      = (LEN_W > TLEN_W) ? LEN_W : TLEN_W;
	localparam int WIDE_W  = (PB > PATTERN_W) ? PB : PATTERN_W;
	localparam int IW      = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
	localparam int UPROD_W = COL_W + CELL_W;
	localparam int VPROD_W = PB + CELL_W;

	// configuration
	logic [MODE_W-1:0]     mode_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [PB-1:0]         top_q, bot_q;
	logic [COL_W-1:0]      columns_q;
	logic [CELL_W-1:0]     cell_w_q, cell_h_q;
	logic [TLEN_W-1:0]     tlen_q;

	// animation state
	logic [PB-1:0]     cur_q;
	logic [TICK_W-1:0] tick_q;
	logic              back_q;
	logic [ADDR_W-1:0] cursor_q;
	logic              stopped_q;
	logic              fin_q;

	// captured item
	logic [OP_W-1:0]    op_q;
	logic [PB-1:0]      val_q;
	logic [INDEX_W-1:0] idx_q;

	// divider and multiplier
	logic [PB-1:0]      quo_q;
	logic [COL_W-1:0]   rem_q;
	logic [UPROD_W-1:0] u_prod_q;
	logic [VPROD_W-1:0] v_prod_q;

	// result
	logic [PATTERN_W-1:0] pattern_q;
	logic [OFFSET_W-1:0]  u_q, v_q;
	logic                 finished_q;

	logic                  cfg_we;
	logic [WIDE_W-1:0]     cfg_pat_wide, in_pat_wide, cur_wide;
	logic [IW-1:0]         idx_wide;
	logic [LW-1:0]         tlen_wide, len, cur_inc;
	logic [ADDR_W-1:0]     cur_eff, cursor_adv;
	logic                  wrap;
	logic [TICK_W-1:0]     tick_inc;
	logic                  fire;
	logic [PB-1:0]         rd_data;
	logic [PB-1:0]         pat_n;
	logic                  back_n, stop_n, fin_n;
	logic [ADDR_W-1:0]     cursor_n;
	logic [TICK_W-1:0]     tick_n;
	logic                  ram_we;
	logic [COL_W-1:0]      divisor;
	logic [COL_W:0]        rem_sh;
	logic                  ge;

	assign cfg_ready    = 1'b1;
	assign cfg_we       = cfg_valid && cfg_ready;
	assign cfg_pat_wide = WIDE_W'(cfg_data[PATTERN_W-1:0]);
	assign in_pat_wide  = WIDE_W'(pattern_value);
	assign idx_wide     = IW'(idx_q);

	// table length clamp and cursor arithmetic
	assign tlen_wide  = LW'(tlen_q);
	assign len        = (tlen_wide > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : tlen_wide;
	assign cur_eff    = (LW'(cursor_q) >= len) ? '0 : cursor_q;
	assign cur_inc    = LW'(cur_eff) + LW'(1);
	assign wrap       = (cur_inc >= len);
	assign cursor_adv = wrap ? '0 : cur_inc[ADDR_W-1:0];

	assign tick_inc = tick_q + TICK_W'(1);
	assign fire     = (tick_inc > TICK_W'(interval_q));

	sfs_ram #(
		.WIDTH (PB),
		.DEPTH (TABLE_DEPTH)
	) u_order_table (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (idx_wide[ADDR_W-1:0]),
		.wr_data (val_q),
		.re      (cmd.rd_table),
		.rd_addr (cur_eff),
		.rd_data (rd_data)
	);

	// next animation state for the captured item
	always_comb begin
		pat_n    = cur_q;
		back_n   = back_q;
		cursor_n = cursor_q;
		stop_n   = stopped_q;
		tick_n   = tick_q;
		fin_n    = 1'b0;
		ram_we   = 1'b0;
		case (op_q)
			OP_TICK: begin
				tick_n = fire ? '0 : tick_inc;
				if (fire && !stopped_q && mode_q != MODE_OFF) begin
					case (mode_q)
						MODE_FWD_LOOP: pat_n = (bot_q > cur_q) ? cur_q + PB'(1) : top_q;
						MODE_REV_LOOP: pat_n = (top_q < cur_q) ? cur_q - PB'(1) : bot_q;
						MODE_FWD_ONCE: begin
							if (bot_q > cur_q) begin
								pat_n = cur_q + PB'(1);
							end else begin
								pat_n = bot_q;
								fin_n = 1'b1;
							end
						end
						MODE_REV_ONCE: begin
							if (top_q < cur_q) begin
								pat_n = cur_q - PB'(1);
							end else begin
								pat_n = top_q;
								fin_n = 1'b1;
							end
						end
						MODE_PINGPONG: begin
							// equal ends hold the pattern
							if (top_q != bot_q) begin
								if (back_q) begin
									if (top_q < cur_q) begin
										pat_n = cur_q - PB'(1);
									end else begin
										pat_n  = cur_q + PB'(1);
										back_n = 1'b0;
									end
								end else begin
									if (bot_q > cur_q) begin
										pat_n = cur_q + PB'(1);
									end else begin
										pat_n  = cur_q - PB'(1);
										back_n = 1'b1;
									end
								end
							end
						end
						MODE_TBL_LOOP, MODE_TBL_ONCE: begin
							if (len != '0) begin
								pat_n    = rd_data;
								cursor_n = cursor_adv;
								if (wrap && mode_q == MODE_TBL_ONCE) fin_n = 1'b1;
							end
						end
						default: ;
					endcase
					if (fin_n) stop_n = 1'b1;
				end
			end
			OP_SET: begin
				if (val_q < top_q) begin
					pat_n = top_q;
				end else if (val_q > bot_q) begin
					pat_n = bot_q;
				end else begin
					pat_n = val_q;
				end
			end
			OP_RESTART: begin
				pat_n  = top_q;
				stop_n = 1'b0;
			end
			default: begin
				ram_we = cmd.update && (int'(idx_q) < TABLE_DEPTH);
			end
		endcase
	end

	// configuration and animation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_FWD_LOOP;
			interval_q <= INTERVAL_RST;
			top_q      <= '0;
			bot_q      <= '0;
			columns_q  <= COLUMNS_RST;
			cell_w_q   <= CELL_RST;
			cell_h_q   <= CELL_RST;
			tlen_q     <= '0;
			cur_q      <= '0;
			tick_q     <= '0;
			back_q     <= 1'b0;
			cursor_q   <= '0;
			stopped_q  <= 1'b0;
		end else begin
			if (cmd.update) begin
				cur_q     <= pat_n;
				tick_q    <= tick_n;
				back_q    <= back_n;
				cursor_q  <= cursor_n;
				stopped_q <= stop_n;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: begin
						mode_q    <= cfg_data[MODE_W-1:0];
						stopped_q <= 1'b0;
					end
					REG_INTERVAL: interval_q <= cfg_data[INTERVAL_W-1:0];
					REG_TOP:      top_q      <= cfg_pat_wide[PB-1:0];
					REG_BOTTOM:   bot_q      <= cfg_pat_wide[PB-1:0];
					REG_COLUMNS:  columns_q  <= cfg_data[COL_W-1:0];
					REG_CELL_W:   cell_w_q   <= cfg_data[CELL_W-1:0];
					REG_CELL_H:   cell_h_q   <= cfg_data[CELL_W-1:0];
					REG_TLEN:     tlen_q     <= cfg_data[TLEN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// restoring divide, one quotient bit a cycle
	assign divisor = (columns_q == '0) ? COL_W'(1) : columns_q;
	assign rem_sh  = {rem_q, quo_q[PB-1]};
	assign ge      = (rem_sh >= {1'b0, divisor});
	assign cur_wide = WIDE_W'(cur_q);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q  <= operation;
			val_q <= in_pat_wide[PB-1:0];
			idx_q <= table_index;
		end
		if (cmd.update) begin
			fin_q <= fin_n;
			quo_q <= pat_n;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[PB-2:0], ge};
			rem_q <= ge ? COL_W'(rem_sh - {1'b0, divisor}) : rem_sh[COL_W-1:0];
		end
		if (cmd.mul) begin
			u_prod_q <= UPROD_W'(rem_q) * UPROD_W'(cell_w_q);
			v_prod_q <= VPROD_W'(quo_q) * VPROD_W'(cell_h_q);
		end
		if (cmd.load_out) begin
			pattern_q  <= cur_wide[PATTERN_W-1:0];
			u_q        <= (|u_prod_q[UPROD_W-1:OFFSET_W]) ? '1 : u_prod_q[OFFSET_W-1:0];
			v_q        <= (|v_prod_q[VPROD_W-1:OFFSET_W]) ? '1 : v_prod_q[OFFSET_W-1:0];
			finished_q <= fin_q;
		end
	end

	assign pattern  = pattern_q;
	assign u_offset = u_q;
	assign v_offset = v_q;
	assign finished = finished_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.div_step) |-> (rem_q < divisor))
		else $error("divider remainder not below column count");

	a_pattern_held: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && !$past(cmd.update)) |-> $stable(cur_q))
		else $error("current pattern changed outside an update");

endmodule

`default_nettype wire

/* hdl/sprite_frame_sequencer.sv */
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// sprite animation pattern sequencer with texture cell offset output
// ----------------------------------------------------------------------------
// usage
//   item channel (item_valid / item_stall): operation, pattern_value and
//   table_index; a beat moves when item_valid is high and item_stall low.
//   operations are a frame tick, a clamped pattern set, a restart at the
//   top pattern, and a write of one custom order table entry
//   result channel (result_valid / result_stall): one beat per item with
//   the pattern, its u/v cell offsets (UQ0.16, saturated) and finished
//   config channel (cfg_valid / cfg_ready): cfg_index selects the register,
//   cfg_data carries the value; cfg_ready is always high, write only while
//   no item is in flight
//   timing: an item runs capture, table read, state update, a bit-serial
//   divide by the column count, multiply and load; item_stall stays high
//   from acceptance until the result is loaded into the output register,
//   so the next item is taken only after the previous one is through
//   a finished result waits in the output register while the next item is
//   accepted; if result_stall is still high when that item completes, the
//   controller holds it until the output register empties
//   reset: registers take their reset values (one column, full-size cells,
//   interval one, forward loop); the order table is undefined until written
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_frame_sequencer #(
	parameter int TABLE_DEPTH  = sfs_pkg::TABLE_DEPTH_DEF,
	parameter int PATTERN_BITS = sfs_pkg::PATTERN_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item channel
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [sfs_pkg::OP_W-1:0]        operation,
	input  logic [sfs_pkg::PATTERN_W-1:0]   pattern_value,
	input  logic [sfs_pkg::INDEX_W-1:0]     table_index,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [sfs_pkg::PATTERN_W-1:0]   pattern,
	output logic [sfs_pkg::OFFSET_W-1:0]    u_offset,
	output logic [sfs_pkg::OFFSET_W-1:0]    v_offset,
	output logic                            finished,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sfs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sfs_pkg::*;

	// command bundle from the sequencer into the datapath
	sfs_cmd_t cmd;

	// controller: item capture, step sequencing and output slot tracking
	sfs_ctrl #(
		.PATTERN_BITS (PATTERN_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	// datapath: registers, animation state, order table, divide and multiply
	sfs_dp #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.PATTERN_BITS (PATTERN_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.operation     (operation),
		.pattern_value (pattern_value),
		.table_index   (table_index),
		.cmd           (cmd),
		.pattern       (pattern),
		.u_offset      (u_offset),
		.v_offset      (v_offset),
		.finished      (finished)
	);

endmodule

`default_nettype wire
